FILE: sv/mjp_pkg.sv
`timescale 1ns / 1ps
package mjp_pkg;

	localparam int TIME_BITS = 32;
	localparam int FRAC_BITS = 24;
	localparam int DATA_BITS = 32;
	localparam int IDX_BITS = 2;
	localparam int INNER_BITS = FRAC_BITS + 4;
	localparam int PROD_BITS = DATA_BITS + INNER_BITS + 1;
	localparam int SHR_BITS = PROD_BITS - FRAC_BITS;
	localparam int LATENCY = FRAC_BITS + 6;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [FRAC_BITS-1:0] frac_t;
	typedef logic [INNER_BITS-1:0] inner_t;
	typedef logic signed [DATA_BITS-1:0] data_t;
	typedef logic [IDX_BITS-1:0] idx_t;

	typedef enum logic [1:0] {
		PH_BEFORE = 2'd0,
		PH_MOVING = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	localparam idx_t REG_AMPLITUDE = idx_t'(0);
	localparam idx_t REG_START     = idx_t'(1);
	localparam idx_t REG_END       = idx_t'(2);

	localparam inner_t TEN_ONE = inner_t'(10) << FRAC_BITS;
	localparam inner_t SIX     = inner_t'(6);
	localparam inner_t FIFTEEN = inner_t'(15);

	typedef struct packed {
		logic   vld;
		phase_t phase;
	} side_t;

endpackage

FILE: sv/mjp_div.sv
`timescale 1ns / 1ps
module mjp_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mjp_pkg::side_t         side_in,
	input  mjp_pkg::time_t         num_in,
	input  mjp_pkg::time_t         den_in,
	output mjp_pkg::side_t         side_out,
	output mjp_pkg::frac_t         quo_out
);

	// One quotient bit per stage; the remainder stays below the divisor when the numerator starts below it.
	mjp_pkg::side_t side_s [0:mjp_pkg::FRAC_BITS];
	mjp_pkg::time_t rem_s  [0:mjp_pkg::FRAC_BITS];
	mjp_pkg::time_t den_s  [0:mjp_pkg::FRAC_BITS];
	mjp_pkg::frac_t quo_s  [0:mjp_pkg::FRAC_BITS];

	assign side_s[0] = side_in;
	assign rem_s[0]  = num_in;
	assign den_s[0]  = den_in;
	assign quo_s[0]  = '0;

	for (genvar k = 0; k < mjp_pkg::FRAC_BITS; k++) begin : g_stage
		logic [mjp_pkg::TIME_BITS:0] sh;
		logic [mjp_pkg::TIME_BITS:0] diff;
		logic                        ge;

		assign sh   = {rem_s[k], 1'b0};
		assign diff = sh - {1'b0, den_s[k]};
		assign ge   = sh >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
			end else begin
				side_s[k+1] <= side_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? mjp_pkg::time_t'(diff) : mjp_pkg::time_t'(sh);
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= mjp_pkg::frac_t'({quo_s[k], ge});
		end
	end

	assign side_out = side_s[mjp_pkg::FRAC_BITS];
	assign quo_out  = quo_s[mjp_pkg::FRAC_BITS];

endmodule

FILE: sv/mjp_poly.sv
`timescale 1ns / 1ps
module mjp_poly (
	input  logic           clk,
	input  logic           arst_n,
	input  mjp_pkg::side_t side_in,
	input  mjp_pkg::frac_t s_in,
	input  mjp_pkg::data_t amplitude,
	output mjp_pkg::side_t side_out,
	output mjp_pkg::data_t pos_out
);

	mjp_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	mjp_pkg::frac_t s_s1, s2_s1, s3_s2;
	mjp_pkg::inner_t inner_s2, p_s3;
	logic signed [mjp_pkg::PROD_BITS-1:0] prod_s4;
	mjp_pkg::data_t pos_s5;

	logic [2*mjp_pkg::FRAC_BITS-1:0] sq;
	logic [2*mjp_pkg::FRAC_BITS-1:0] cube;
	logic [mjp_pkg::FRAC_BITS+mjp_pkg::INNER_BITS-1:0] pm;
	mjp_pkg::inner_t inner;
	logic signed [mjp_pkg::PROD_BITS-1:0] prod;
	logic signed [mjp_pkg::SHR_BITS-1:0] shr;
	logic [mjp_pkg::SHR_BITS-mjp_pkg::DATA_BITS:0] hi;
	mjp_pkg::data_t sat;
	mjp_pkg::data_t pos_next;

	assign sq    = s_in * s_in;
	assign cube  = s2_s1 * s_s1;
	assign inner = mjp_pkg::TEN_ONE + mjp_pkg::SIX * mjp_pkg::inner_t'(s2_s1)
		- mjp_pkg::FIFTEEN * mjp_pkg::inner_t'(s_s1);
	assign pm    = s3_s2 * inner_s2;
	assign prod  = amplitude * $signed({1'b0, p_s3});

	// Arithmetic shift rounds toward minus infinity.
	assign shr = mjp_pkg::SHR_BITS'(prod_s4 >>> mjp_pkg::FRAC_BITS);
	assign hi  = shr[mjp_pkg::SHR_BITS-1:mjp_pkg::DATA_BITS-1];

	always_comb begin
		if ((&hi) || !(|hi)) begin
			sat = mjp_pkg::data_t'(shr);
		end else if (shr[mjp_pkg::SHR_BITS-1]) begin
			sat = {1'b1, {(mjp_pkg::DATA_BITS-1){1'b0}}};
		end else begin
			sat = {1'b0, {(mjp_pkg::DATA_BITS-1){1'b1}}};
		end
		case (side_s4.phase)
			mjp_pkg::PH_BEFORE: pos_next = '0;
			mjp_pkg::PH_DONE:   pos_next = amplitude;
			default:            pos_next = sat;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		s_s1     <= s_in;
		s2_s1    <= mjp_pkg::frac_t'(sq >> mjp_pkg::FRAC_BITS);
		s3_s2    <= mjp_pkg::frac_t'(cube >> mjp_pkg::FRAC_BITS);
		inner_s2 <= inner;
		p_s3     <= mjp_pkg::inner_t'(pm >> mjp_pkg::FRAC_BITS);
		prod_s4  <= prod;
		pos_s5   <= pos_next;
	end

	assign side_out = side_s5;
	assign pos_out  = pos_s5;

endmodule

FILE: sv/minimum_jerk_profile.sv
`timescale 1ns / 1ps
// Channel   Handshake        Payload
// input     start / busy     sample_time
// result    done (strobe)    position, phase
// config    wr_en            wr_idx, wr_data
//
// One sample is taken every cycle; busy is always low.
// Each result follows its sample through the compare stage, the 24-stage divider that
// forms one fraction bit per stage, and the polynomial stages.
// Reset clears the config registers and the valid bits to zero, which empties the pipeline.
// The receiver cannot stall, so the pipeline never holds.
module minimum_jerk_profile (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [31:0]          sample_time,
	output logic                 done,
	output logic signed [31:0]   position,
	output logic [1:0]           phase,
	input  logic                 wr_en,
	input  logic [1:0]           wr_idx,
	input  logic [31:0]          wr_data
);

	mjp_pkg::data_t amp_q;
	logic [31:0] start_q, end_q;

	mjp_pkg::side_t side_s1, side_div, side_out;
	mjp_pkg::time_t num_s1, den_s1;
	mjp_pkg::frac_t quo;
	mjp_pkg::data_t pos;

	mjp_pkg::time_t t, ts, te;
	mjp_pkg::phase_t ph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				mjp_pkg::REG_AMPLITUDE: amp_q   <= wr_data;
				mjp_pkg::REG_START:     start_q <= wr_data;
				mjp_pkg::REG_END:       end_q   <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	assign t    = mjp_pkg::time_t'(sample_time);
	assign ts   = mjp_pkg::time_t'(start_q);
	assign te   = mjp_pkg::time_t'(end_q);

	always_comb begin
		if (t < ts) begin
			ph = mjp_pkg::PH_BEFORE;
		end else if (t < te) begin
			ph = mjp_pkg::PH_MOVING;
		end else begin
			ph = mjp_pkg::PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.vld   <= start && !busy;
			side_s1.phase <= ph;
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= t - ts;
		den_s1 <= te - ts;
	end

	mjp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_s1),
		.num_in   (num_s1),
		.den_in   (den_s1),
		.side_out (side_div),
		.quo_out  (quo)
	);

	mjp_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.side_in   (side_div),
		.s_in      (quo),
		.amplitude (amp_q),
		.side_out  (side_out),
		.pos_out   (pos)
	);

	assign done     = side_out.vld;
	assign phase    = side_out.phase;
	assign position = pos;

endmodule

FILE: sv/mjp_checker.sv
`timescale 1ns / 1ps
module mjp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] position,
	input logic [1:0]         phase
);

	// Every result beat comes from an earlier accepted sample.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, mjp_pkg::LATENCY))
		else $error("result beat without a matching sample");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (phase == mjp_pkg::PH_BEFORE || phase == mjp_pkg::PH_MOVING
			|| phase == mjp_pkg::PH_DONE))
		else $error("unused phase code on a result beat");

	a_before_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && phase == mjp_pkg::PH_BEFORE) |-> position == '0)
		else $error("nonzero position before the move");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a fully pipelined block");

endmodule

bind minimum_jerk_profile mjp_checker u_chk (.*);
